// File: sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg - shared types and constants of the bitmap first-fit allocator
// Map geometry, operation and status codes, the input and output beat structs,
// and the control and result structs passed between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

    // Managed blocks; must be a multiple of WORD_W.
    localparam int MAX_BLOCKS = 1024;

    // The map is held as rows of WORD_W bits, one row scanned per cycle.
    localparam int WORD_W    = 8;
    localparam int WORD_SH   = $clog2(WORD_W);
    localparam int MAP_DEPTH = MAX_BLOCKS / WORD_W;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int NW_W      = $clog2(MAP_DEPTH + 1);
    localparam int IDX_W     = $clog2(MAX_BLOCKS);
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [1:0] OP_MARK_USED = 2'd0;
    localparam logic [1:0] OP_MARK_FREE = 2'd1;
    localparam logic [1:0] OP_FIND      = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  block_index;
        logic [10:0] run_length;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  run_start;
        logic [10:0] free_count;
        logic [10:0] largest_run;
    } t_out_beat;

    typedef struct packed {
        logic clear;
        logic step;
        logic search;
    } t_scan_ctl;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] start;
        logic [CNT_W-1:0] free;
        logic [CNT_W-1:0] best;
    } t_scan_res;

endpackage

`default_nettype wire

// File: sv/bffa_map.sv
// ----------------------------------------------------------------------------
// bffa_map - occupancy map storage
// One write port and one registered read port over rows of map bits. Each
// row has a valid bit cleared at reset; a row never written reads as free.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_map (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [bffa_pkg::ADDR_W-1:0]         i_wr_addr,
    input  wire logic [bffa_pkg::WORD_W-1:0]         i_wr_data,
    input  wire logic                                i_rd_en,
    input  wire logic [bffa_pkg::ADDR_W-1:0]         i_rd_addr,
    output logic      [bffa_pkg::WORD_W-1:0]         o_rd_data
);

    localparam int DEPTH = bffa_pkg::MAP_DEPTH;
    localparam int WW    = bffa_pkg::WORD_W;

    logic [WW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [WW-1:0]    r_rd_data;
    logic             r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_row_vld[i_rd_addr];
            end
        end
    end

    // Unwritten rows are all free.
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: sv/bffa_scan.sv
// ----------------------------------------------------------------------------
// bffa_scan - shared run scanner
// Consumes one map row per step, lowest block first, and accumulates the free
// count, the longest free run and the first run that reaches the wanted size.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bffa_pkg::t_scan_ctl           i_ctl,
    input  wire logic [bffa_pkg::WORD_W-1:0]   i_word,
    input  wire logic [bffa_pkg::ADDR_W-1:0]   i_base,
    input  wire logic [bffa_pkg::CNT_W-1:0]    i_n,
    input  wire logic [bffa_pkg::CNT_W-1:0]    i_need,
    output bffa_pkg::t_scan_res                o_res
);

    localparam int WW  = bffa_pkg::WORD_W;
    localparam int WSH = bffa_pkg::WORD_SH;
    localparam int IW  = bffa_pkg::IDX_W;
    localparam int CW  = bffa_pkg::CNT_W;

    logic [CW-1:0] r_run,  n_run;
    logic [CW-1:0] r_best, n_best;
    logic [CW-1:0] r_free, n_free;
    logic          r_found, n_found;
    logic [IW-1:0] r_start, n_start;

    always_comb begin
        logic [IW-1:0] pos_v;
        logic [CW-1:0] sum_v;
        n_run   = r_run;
        n_best  = r_best;
        n_free  = r_free;
        n_found = r_found;
        n_start = r_start;
        for (int i = 0; i < WW; i++) begin
            pos_v = {i_base, WSH'(i)};
            sum_v = CW'(pos_v) + CW'(1);
            // Blocks past the active range are neither counted nor searched.
            if (CW'(pos_v) < i_n) begin
                if (!i_word[i]) begin
                    n_run  = n_run + CW'(1);
                    n_free = n_free + CW'(1);
                    if (n_run > n_best) begin
                        n_best = n_run;
                    end
                    if (i_ctl.search && !n_found && n_run == i_need) begin
                        n_found = 1'b1;
                        n_start = IW'(sum_v - i_need);
                    end
                end else begin
                    n_run = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_best  <= '0;
            r_free  <= '0;
            r_found <= 1'b0;
            r_start <= '0;
        end else if (i_ctl.clear) begin
            r_run   <= '0;
            r_best  <= '0;
            r_free  <= '0;
            r_found <= 1'b0;
            r_start <= '0;
        end else if (i_ctl.step) begin
            r_run   <= n_run;
            r_best  <= n_best;
            r_free  <= n_free;
            r_found <= n_found;
            r_start <= n_start;
        end
    end

    assign o_res.found = r_found;
    assign o_res.start = r_start;
    assign o_res.free  = r_free;
    assign o_res.best  = r_best;

endmodule

`default_nettype wire

// File: sv/bitmap_first_fit_allocator_core.sv
// Flow: a find or an invalid op goes from the taken input beat through a sweep of the
// active rows (n = active blocks) to S_DONE, where the result is registered; a valid
// mark first reads its row and writes it back (S_RD, S_WR), then sweeps the same way.
// A new input beat is taken only in S_IDLE, once the last result has been loaded; the
// sweep is set by the single map read port delivering one 8-block row per cycle.
// Reset: every block reads free at once (per-row valid bits), block count = 1024,
// no clearing pass; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_core - bitmap first-fit block allocator
// Sequencer around the occupancy map and the shared row scanner: for a valid mark
// it marks a block, and for every op it sweeps the active rows to report free
// count, longest run and, for a find, the first fitting run.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_allocator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire bffa_pkg::t_in_beat                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output bffa_pkg::t_out_beat                      o_out_data,
    input  wire logic                                i_cfg_we,
    input  wire logic [bffa_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int AW   = bffa_pkg::ADDR_W;
    localparam int NWW  = bffa_pkg::NW_W;
    localparam int IW   = bffa_pkg::IDX_W;
    localparam int CW   = bffa_pkg::CNT_W;
    localparam int WW   = bffa_pkg::WORD_W;
    localparam int WSH  = bffa_pkg::WORD_SH;
    localparam int MAXB = bffa_pkg::MAX_BLOCKS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_WR   = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    bffa_pkg::t_in_beat       r_in;
    logic [bffa_pkg::CFG_W-1:0] r_blocks;
    logic [NWW-1:0]           r_issue;
    logic                     r_rd_vld;
    logic [AW-1:0]            r_rd_base;
    logic                     r_out_valid;
    bffa_pkg::t_out_beat      r_out;

    logic [CW-1:0]            w_n;
    logic [CW:0]              w_round;
    logic [NWW-1:0]           w_nwords;
    logic [IW-1:0]            w_idx;
    logic                     w_accept;
    logic                     w_in_mark_ok;
    logic                     w_mark_ok;
    logic                     w_need_ok;
    logic                     w_scan_rd;
    logic                     w_rd_en;
    logic [AW-1:0]            w_rd_addr;
    logic                     w_wr_en;
    logic [WW-1:0]            w_map_rdata;
    logic [WW-1:0]            w_wr_data;
    logic                     w_load;
    bffa_pkg::t_scan_ctl      w_ctl;
    bffa_pkg::t_scan_res      w_scan;
    bffa_pkg::t_out_beat      w_out;

    // Active block count, saturated to the map size.
    assign w_n      = (32'(r_blocks) > 32'(MAXB)) ? CW'(MAXB) : CW'(r_blocks);
    assign w_round  = {1'b0, w_n} + (CW+1)'(WW - 1);
    assign w_nwords = w_round[WSH +: NWW];
    assign w_idx    = IW'(r_in.block_index);

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_in_mark_ok = (i_in_data.op == bffa_pkg::OP_MARK_USED ||
                           i_in_data.op == bffa_pkg::OP_MARK_FREE) &&
                          (32'(i_in_data.block_index) < 32'(w_n));
    assign w_mark_ok    = (r_in.op == bffa_pkg::OP_MARK_USED ||
                           r_in.op == bffa_pkg::OP_MARK_FREE) &&
                          (32'(r_in.block_index) < 32'(w_n));
    assign w_need_ok    = (r_in.run_length != '0) && (32'(r_in.run_length) <= 32'(w_n));

    assign w_scan_rd = (r_state == S_SCAN) && (r_issue < w_nwords);
    assign w_rd_en   = w_scan_rd || (r_state == S_RD);
    assign w_rd_addr = (r_state == S_RD) ? w_idx[IW-1:WSH] : r_issue[AW-1:0];
    assign w_wr_en   = (r_state == S_WR);

    // Read-modify-write of the row holding the marked block.
    always_comb begin
        w_wr_data = w_map_rdata;
        w_wr_data[w_idx[WSH-1:0]] = (r_in.op == bffa_pkg::OP_MARK_USED);
    end

    bffa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_idx[IW-1:WSH]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_map_rdata)
    );

    assign w_ctl.clear  = w_accept;
    assign w_ctl.step   = r_rd_vld;
    assign w_ctl.search = (r_in.op == bffa_pkg::OP_FIND) && w_need_ok;

    bffa_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_word  (w_map_rdata),
        .i_base  (r_rd_base),
        .i_n     (w_n),
        .i_need  (CW'(r_in.run_length)),
        .o_res   (w_scan)
    );

    // Result assembly.
    always_comb begin
        w_out.run_start   = '0;
        w_out.free_count  = 11'(w_scan.free);
        w_out.largest_run = 11'(w_scan.best);
        priority if (r_in.op == bffa_pkg::OP_MARK_USED || r_in.op == bffa_pkg::OP_MARK_FREE) begin
            w_out.status = w_mark_ok ? bffa_pkg::ST_OK : bffa_pkg::ST_INVALID;
        end else if (r_in.op == bffa_pkg::OP_FIND && w_need_ok) begin
            if (w_scan.found) begin
                w_out.status    = bffa_pkg::ST_OK;
                w_out.run_start = 10'(w_scan.start);
            end else begin
                w_out.status = bffa_pkg::ST_NOSPACE;
            end
        end else begin
            w_out.status = bffa_pkg::ST_INVALID;
        end
    end

    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_mark_ok ? S_RD : S_SCAN;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_issue == w_nwords && !r_rd_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_blocks    <= bffa_pkg::CFG_RESET;
            r_issue     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_scan_rd;
            if (i_cfg_we) begin
                r_blocks <= i_cfg_data;
            end
            if (w_accept) begin
                r_issue <= '0;
            end else if (w_scan_rd) begin
                r_issue <= r_issue + NWW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_scan_rd) begin
            r_rd_base <= r_issue[AW-1:0];
        end
        if (w_load) begin
            r_out <= w_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (w_scan.free <= w_n))
        else $error("free count exceeds active blocks");

    a_run_within_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.largest_run <= o_out_data.free_count))
        else $error("longest run exceeds free count");

    a_fit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_scan.found) |->
        ((32'(w_scan.start) + 32'(r_in.run_length)) <= 32'(w_n)))
        else $error("found run extends past active blocks");

endmodule

`default_nettype wire
